/* rtl/core/esd_pkg.sv */
// Shared constants and result type for the escape stuffing deframer.
package esd_pkg;

    localparam logic [7:0] ESC_BYTE = 8'h1b;
    localparam logic [7:0] END_BYTE = 8'h04;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOBUF    = 2'd1;
    localparam logic [1:0] ST_PROTOCOL = 2'd2;

    localparam logic [31:0] BUFFER_SIZE_RESET = 32'd2048;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_end;
        logic [1:0]  frame_status;
        logic [31:0] frame_length;
    } t_result;

endpackage

/* rtl/core/esd_out_fifo.sv */
// Two-entry result queue that decouples the deframer from the output stall.
module esd_out_fifo
    import esd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    t_result    r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop      = (r_count != 2'd0) && !i_stall;
    assign o_valid  = (r_count != 2'd0);
    assign o_full   = (r_count == 2'd2);
    assign o_result = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_result;
        end
    end

endmodule

/* rtl/core/escape_stuffing_deframer.sv */
// Escape stuffing deframer with length prefix: takes one received byte per cycle
// and emits unescaped payload bytes plus one end-of-frame beat per frame with
// status (ok, no_buffer, protocol_error) and delivered length. The phase/count
// state updates in a single registered step and each result lands in a two-beat
// output queue, so the input stalls only while that queue is full. buffer_size
// (APB byte address 0, reset 2048) is sampled when the fourth length byte
// arrives.
module escape_stuffing_deframer
    import esd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_frame_end,
    output logic [1:0]  o_frame_status,
    output logic [31:0] o_frame_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DISCARD,
        PH_TRAILER
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hcnt, n_hcnt;
    logic [31:0] r_len, n_len;
    logic [31:0] r_remain, n_remain;
    logic        r_esc, n_esc;
    logic        r_extra, n_extra;
    logic [31:0] r_buffer_size;

    logic        accept;
    logic        push;
    t_result     res;
    logic        fifo_full;
    t_result     out_res;
    logic [31:0] hdr_len;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : r_buffer_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUFFER_SIZE_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_buffer_size <= pwdata;
        end
    end

    assign o_stall = fifo_full;
    assign accept  = i_valid && !fifo_full;
    assign hdr_len = {r_len[23:0], i_rx_byte};

    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_len    = r_len;
        n_remain = r_remain;
        n_esc    = r_esc;
        n_extra  = r_extra;
        push     = 1'b0;
        res      = '0;
        case (r_phase)
            PH_HEADER: begin
                n_len  = hdr_len;
                n_hcnt = r_hcnt + 2'd1;
                if (r_hcnt == 2'd3) begin
                    n_esc   = 1'b0;
                    n_extra = 1'b0;
                    if (hdr_len > r_buffer_size) begin
                        n_phase = PH_DISCARD;
                    end else if (hdr_len == 32'd0) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        n_remain = hdr_len;
                        n_phase  = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (!r_esc && i_rx_byte == ESC_BYTE) begin
                    n_esc = 1'b1;
                end else if (!r_esc && i_rx_byte == END_BYTE) begin
                    push             = 1'b1;
                    res.frame_end    = 1'b1;
                    res.frame_status = ST_PROTOCOL;
                    res.frame_length = r_len - r_remain;
                    n_phase          = PH_HEADER;
                    n_hcnt           = 2'd0;
                    n_esc            = 1'b0;
                    n_extra          = 1'b0;
                end else begin
                    push          = 1'b1;
                    res.data_byte = i_rx_byte;
                    n_esc         = 1'b0;
                    n_remain      = r_remain - 32'd1;
                    if (r_remain == 32'd1) begin
                        n_phase = PH_TRAILER;
                        n_extra = 1'b0;
                    end
                end
            end
            PH_DISCARD: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_rx_byte == ESC_BYTE) begin
                    n_esc = 1'b1;
                end else if (i_rx_byte == END_BYTE) begin
                    push             = 1'b1;
                    res.frame_end    = 1'b1;
                    res.frame_status = ST_NOBUF;
                    n_phase          = PH_HEADER;
                    n_hcnt           = 2'd0;
                    n_extra          = 1'b0;
                end
            end
            PH_TRAILER: begin
                if (!r_esc && i_rx_byte == END_BYTE) begin
                    push             = 1'b1;
                    res.frame_end    = 1'b1;
                    res.frame_status = r_extra ? ST_PROTOCOL : ST_OK;
                    res.frame_length = r_len;
                    n_phase          = PH_HEADER;
                    n_hcnt           = 2'd0;
                    n_esc            = 1'b0;
                    n_extra          = 1'b0;
                end else begin
                    // any other byte, escaped or not, marks trailing garbage
                    n_esc   = !r_esc && (i_rx_byte == ESC_BYTE);
                    n_extra = 1'b1;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hcnt   <= 2'd0;
            r_len    <= 32'd0;
            r_remain <= 32'd0;
            r_esc    <= 1'b0;
            r_extra  <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_len    <= n_len;
            r_remain <= n_remain;
            r_esc    <= n_esc;
            r_extra  <= n_extra;
        end
    end

    esd_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept && push),
        .i_result (res),
        .o_full   (fifo_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_res)
    );

    assign o_data_byte    = out_res.data_byte;
    assign o_frame_end    = out_res.frame_end;
    assign o_frame_status = out_res.frame_status;
    assign o_frame_length = out_res.frame_length;

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_frame_status != 2'd3)
        else $error("end beat carries an undefined status");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_end |-> o_frame_status == ST_OK && o_frame_length == 32'd0)
        else $error("data beat carries frame fields");

    a_end_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && push && res.frame_end |=> r_phase == PH_HEADER && r_hcnt == 2'd0)
        else $error("frame end did not return to header phase");

    a_full_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with an empty result queue");

endmodule
